// ===== design/krt_pkg.sv =====
// Shared types, codes and field widths for the keyed record table.
// Used by keyed_record_table; no dependencies.
package krt_pkg;

  localparam int CAPACITY_DEF = 10;
  localparam int KEY_W        = 16;
  localparam int YEAR_W       = 8;
  localparam int SUBJ_W       = 8;
  localparam int GRADE_W      = 7;
  localparam int USED_W       = 4;
  localparam int REC_W        = KEY_W + YEAR_W + 3 * SUBJ_W + 3 * GRADE_W;
  localparam int IN_DATA_W    = ((REC_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((REC_W + USED_W + 1 + 7) / 8) * 8;
  localparam logic [GRADE_W-1:0] GRADE_MAX = GRADE_W'(100);

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_READ = 2'd2,
    CMD_LIST = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  function automatic logic [GRADE_W-1:0] sat_grade(input logic [GRADE_W-1:0] g);
    sat_grade = (g > GRADE_MAX) ? GRADE_MAX : g;
  endfunction

endpackage

// ===== design/krt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds until the next read enable; no dependencies.
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/keyed_record_table.sv =====
// Keyed record table top level: insertion-ordered record store in one RAM.
// Depends on krt_pkg and krt_ram.
//
//  channel | direction | tdata / tuser / tlast
//  in_     | slave     | record fields / command / -
//  out_    | master    | record, used count, full / status / last result of command
//
// Add, and any command on an empty table, go straight from idle to the result state.
// Read and delete scan the RAM one entry per S_RD/S_CMP pass (registered read port);
// delete then moves each later entry down via S_SHIFT and S_SHW. List: one key per pass, waiting on a stall.
// Reset clears the count, state and output valid only; RAM contents are never read beyond the count.
// A stalled result holds in the output register; the sequencer waits for it.
module keyed_record_table #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [krt_pkg::IN_DATA_W-1:0]   in_tdata,  // key_id, year_in, subject_a/b/c_in, grade_a/b/c_in
  input  logic [1:0]                      in_tuser,  // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [krt_pkg::OUT_DATA_W-1:0]  out_tdata, // key_out, year_out, subject_a/b/c_out,
                                                     // grade_a/b/c_out, used_count, full_flag
  output logic [1:0]                      out_tuser, // status
  output logic                            out_tlast  // last_flag
);
  import krt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SHIFT,
    S_SHW,
    S_RESP
  } state_t;

  state_t              state_r;
  cmd_t                cmd_r;
  status_t             status_r;
  logic [KEY_W-1:0]    key_r;
  logic [AW-1:0]       ptr_r;
  logic [CW-1:0]       count_r;
  logic                out_tvalid_r;
  logic [REC_W-1:0]    out_rec_r;
  status_t             out_status_r;
  logic [USED_W-1:0]   out_used_r;
  logic                out_full_r;
  logic                out_last_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [REC_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [REC_W-1:0]    ram_rdata;
  logic [REC_W-1:0]    in_rec;
  logic                in_xfer;
  logic                out_free;
  logic                out_load;
  logic                full;
  logic                at_last;
  logic                more_after;
  logic                hit;
  logic [AW-1:0]       ptr_inc;
  logic [CW-1:0]       ptr_ext_inc;

  assign in_xfer     = in_tvalid && in_tready;
  assign in_tready   = (state_r == S_IDLE);
  assign out_free    = !out_tvalid_r || out_tready;
  assign out_load    = out_free && ((state_r == S_RESP) ||
                       (state_r == S_CMP && (cmd_r == CMD_LIST || (hit && cmd_r != CMD_DEL))));
  assign full        = (count_r == CW'(CAPACITY));
  assign ptr_inc     = ptr_r + AW'(1);
  assign ptr_ext_inc = CW'(ptr_r) + CW'(1);
  assign at_last     = (ptr_ext_inc == count_r);
  assign more_after  = (ptr_ext_inc < count_r);
  assign hit         = (ram_rdata[KEY_W-1:0] == key_r);

  assign in_rec = {
    sat_grade(in_tdata[KEY_W+YEAR_W+3*SUBJ_W+2*GRADE_W +: GRADE_W]),
    sat_grade(in_tdata[KEY_W+YEAR_W+3*SUBJ_W+GRADE_W +: GRADE_W]),
    sat_grade(in_tdata[KEY_W+YEAR_W+3*SUBJ_W +: GRADE_W]),
    in_tdata[KEY_W+YEAR_W+3*SUBJ_W-1:0]
  };

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_r;
    case (state_r)
      S_IDLE: begin
        ram_we    = in_xfer && (cmd_t'(in_tuser) == CMD_ADD) && !full;
        ram_waddr = count_r[AW-1:0];
        ram_wdata = in_rec;
      end
      S_RD: begin
        ram_re = 1'b1;
      end
      S_SHIFT: begin
        ram_re    = more_after;
        ram_raddr = ptr_inc;
      end
      S_SHW: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready && !out_load) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            cmd_r <= cmd_t'(in_tuser);
            key_r <= in_tdata[KEY_W-1:0];
            ptr_r <= '0;
            if (cmd_t'(in_tuser) == CMD_ADD) begin
              if (full) begin
                status_r <= ST_FULL;
              end else begin
                status_r <= ST_OK;
                count_r  <= count_r + CW'(1);
              end
              state_r <= S_RESP;
            end else if (count_r == '0) begin
              status_r <= ST_EMPTY;
              state_r  <= S_RESP;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (cmd_r == CMD_LIST) begin
            if (out_free) begin
              out_tvalid_r <= 1'b1;
              out_rec_r    <= {{(REC_W-KEY_W){1'b0}}, ram_rdata[KEY_W-1:0]};
              out_status_r <= ST_OK;
              out_used_r   <= USED_W'(count_r);
              out_full_r   <= full;
              out_last_r   <= at_last;
              ptr_r        <= ptr_inc;
              state_r      <= at_last ? S_IDLE : S_RD;
            end
          end else if (hit) begin
            if (cmd_r == CMD_DEL) begin
              state_r <= S_SHIFT;
            end else if (out_free) begin
              out_tvalid_r <= 1'b1;
              out_rec_r    <= ram_rdata;
              out_status_r <= ST_OK;
              out_used_r   <= USED_W'(count_r);
              out_full_r   <= full;
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else if (at_last) begin
            status_r <= ST_NOTFOUND;
            state_r  <= S_RESP;
          end else begin
            ptr_r   <= ptr_inc;
            state_r <= S_RD;
          end
        end
        S_SHIFT: begin
          if (more_after) begin
            state_r <= S_SHW;
          end else begin
            count_r  <= count_r - CW'(1);
            status_r <= ST_OK;
            state_r  <= S_RESP;
          end
        end
        S_SHW: begin
          ptr_r   <= ptr_inc;
          state_r <= S_SHIFT;
        end
        S_RESP: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_rec_r    <= '0;
            out_status_r <= status_r;
            out_used_r   <= USED_W'(count_r);
            out_full_r   <= full;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-REC_W-USED_W-1){1'b0}}, out_full_r, out_used_r, out_rec_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("record count beyond capacity");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_SHW))
    else $error("RAM write outside add or shift");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("accepted command not processed");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_status_r != ST_OK) |-> out_tlast)
    else $error("error result without last mark");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

endmodule

// ===== dv/tb_keyed_record_table.sv =====
// Testbench for keyed_record_table: directed table plus random command stream,
// each result checked against a shadow copy of the record table or a directed row's reply.
// Depends on krt_pkg and the keyed_record_table RTL.
`timescale 1ns / 100ps

module tb_keyed_record_table;
  import krt_pkg::*;

  localparam int CAP           = CAPACITY_DEF;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 50;
  localparam int TAIL_CYCLES   = 60;

  typedef struct packed {
    cmd_t             cmd;
    logic [15:0]      key;
    logic [7:0]       year;
    logic [7:0]       subj_a;
    logic [7:0]       subj_b;
    logic [7:0]       subj_c;
    logic [6:0]       grade_a;
    logic [6:0]       grade_b;
    logic [6:0]       grade_c;
  } table_cmd_t;

  typedef struct packed {
    status_t          status;
    logic [15:0]      key;
    logic [7:0]       year;
    logic [7:0]       subj_a;
    logic [7:0]       subj_b;
    logic [7:0]       subj_c;
    logic [6:0]       grade_a;
    logic [6:0]       grade_b;
    logic [6:0]       grade_c;
    logic [3:0]       used;
    logic             full;
    logic             last;
  } reply_t;

  typedef struct packed {
    table_cmd_t       item;
    logic             typed;
    reply_t           want;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;  // key_id, year_in, subject_a/b/c_in, grade_a/b/c_in
  logic [1:0]             in_tuser   = '0;  // command
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;        // key_out, year_out, subject_a/b/c_out,
                                            // grade_a/b/c_out, used_count, full_flag
  logic [1:0]             out_tuser;        // status
  logic                   out_tlast;        // last_flag

  table_cmd_t  shadow_recs [CAP];
  logic [15:0] shadow_keys [CAP];
  int unsigned shadow_count = 0;
  reply_t      pending_replies [$];
  dir_row_t    directed_rows [$];

  int          mismatches     = 0;
  int          quiet_cycles   = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        hold_start     = 1'b0;
  logic        hold_rx        = 1'b0;
  int          idle_plan  [4] = '{0, 56, 0, 29};
  int          stall_plan [4] = '{0, 0, 56, 29};
  reply_t      got;
  reply_t      want;

  keyed_record_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [6:0] clamp_grade(input logic [6:0] g);
    clamp_grade = (g > 7'd100) ? 7'd100 : g;
  endfunction

  task automatic table_apply(input table_cmd_t c, input bit push);
    reply_t      r;
    reply_t      burst [$];
    int          idx;
    int unsigned i;
    r   = '0;
    idx = -1;
    if (c.cmd == CMD_ADD) begin
      if (shadow_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        shadow_keys[shadow_count]         = c.key;
        shadow_recs[shadow_count]         = c;
        shadow_recs[shadow_count].grade_a = clamp_grade(c.grade_a);
        shadow_recs[shadow_count].grade_b = clamp_grade(c.grade_b);
        shadow_recs[shadow_count].grade_c = clamp_grade(c.grade_c);
        shadow_count++;
        r.status = ST_OK;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else if (c.cmd != CMD_LIST) begin
      for (i = 0; i < shadow_count; i++) begin
        if (idx < 0 && shadow_keys[i] == c.key) idx = i;
      end
      if (idx < 0) begin
        r.status = ST_NOTFOUND;
      end else if (c.cmd == CMD_DEL) begin
        for (i = idx; i + 1 < shadow_count; i++) begin
          shadow_keys[i] = shadow_keys[i+1];
          shadow_recs[i] = shadow_recs[i+1];
        end
        shadow_count--;
        r.status = ST_OK;
      end else begin
        r.status  = ST_OK;
        r.key     = shadow_keys[idx];
        r.year    = shadow_recs[idx].year;
        r.subj_a  = shadow_recs[idx].subj_a;
        r.subj_b  = shadow_recs[idx].subj_b;
        r.subj_c  = shadow_recs[idx].subj_c;
        r.grade_a = shadow_recs[idx].grade_a;
        r.grade_b = shadow_recs[idx].grade_b;
        r.grade_c = shadow_recs[idx].grade_c;
      end
    end
    if (c.cmd == CMD_LIST && shadow_count != 0) begin
      for (i = 0; i < shadow_count; i++) begin
        r        = '0;
        r.status = ST_OK;
        r.key    = shadow_keys[i];
        r.used   = 4'(shadow_count);
        r.full   = (shadow_count == CAP);
        r.last   = (i + 1 == shadow_count);
        burst.push_back(r);
      end
    end else begin
      r.used = 4'(shadow_count);
      r.full = (shadow_count == CAP);
      r.last = 1'b1;
      burst.push_back(r);
    end
    if (push) begin
      foreach (burst[j]) pending_replies.push_back(burst[j]);
    end
  endtask

  function automatic dir_row_t dr(input cmd_t cmd, input logic [15:0] key,
                                  input logic [7:0] year, input logic [7:0] sa,
                                  input logic [7:0] sb, input logic [7:0] sc,
                                  input logic [6:0] ga, input logic [6:0] gb,
                                  input logic [6:0] gc, input logic typed,
                                  input status_t st, input int used);
    dir_row_t row;
    row              = '0;
    row.item.cmd     = cmd;
    row.item.key     = key;
    row.item.year    = year;
    row.item.subj_a  = sa;
    row.item.subj_b  = sb;
    row.item.subj_c  = sc;
    row.item.grade_a = ga;
    row.item.grade_b = gb;
    row.item.grade_c = gc;
    row.typed        = typed;
    row.want.status  = st;
    row.want.used    = 4'(used);
    row.want.full    = (used == CAP);
    row.want.last    = 1'b1;
    return row;
  endfunction

  function automatic table_cmd_t random_cmd();
    table_cmd_t c;
    int         r;
    r = $urandom_range(99);
    if (r < 30)      c.cmd = CMD_ADD;
    else if (r < 65) c.cmd = CMD_DEL;
    else if (r < 85) c.cmd = CMD_READ;
    else             c.cmd = CMD_LIST;
    c.year    = 8'($urandom);
    c.subj_a  = 8'($urandom);
    c.subj_b  = 8'($urandom);
    c.subj_c  = 8'($urandom);
    c.grade_a = 7'($urandom_range(127));
    c.grade_b = 7'($urandom_range(127));
    c.grade_c = 7'($urandom_range(127));
    // bias delete and read toward keys that are live in the table
    if (c.cmd != CMD_ADD && shadow_count > 0 && $urandom_range(9) < 7)
      c.key = shadow_keys[$urandom_range(shadow_count - 1)];
    else if ($urandom_range(3) == 0)
      c.key = 16'($urandom);
    else
      c.key = 16'($urandom_range(7)) ^ ($urandom_range(1) ? 16'hFFFF : 16'h0000);
    return c;
  endfunction

  task automatic send_cmd(input table_cmd_t c, input logic typed, input reply_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.cmd;
    in_tdata  <= {3'b000, c.grade_c, c.grade_b, c.grade_a,
                  c.subj_c, c.subj_b, c.subj_a, c.year, c.key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    table_apply(c, !typed);
    if (typed) pending_replies.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_tready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    while (!hold_start) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("keyed_record_table: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = status_t'(out_tuser);
      got.key     = out_tdata[15:0];
      got.year    = out_tdata[23:16];
      got.subj_a  = out_tdata[31:24];
      got.subj_b  = out_tdata[39:32];
      got.subj_c  = out_tdata[47:40];
      got.grade_a = out_tdata[54:48];
      got.grade_b = out_tdata[61:55];
      got.grade_c = out_tdata[68:62];
      got.used    = out_tdata[72:69];
      got.full    = out_tdata[73];
      got.last    = out_tlast;
      if (pending_replies.size() == 0) begin
        $error("result with none pending: status %0d key_out %h", got.status, got.key);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status",        want.status,  got.status);
        check_field("key_out",       want.key,     got.key);
        check_field("year_out",      want.year,    got.year);
        check_field("subject_a_out", want.subj_a,  got.subj_a);
        check_field("subject_b_out", want.subj_b,  got.subj_b);
        check_field("subject_c_out", want.subj_c,  got.subj_c);
        check_field("grade_a_out",   want.grade_a, got.grade_a);
        check_field("grade_b_out",   want.grade_b, got.grade_b);
        check_field("grade_c_out",   want.grade_c, got.grade_c);
        check_field("used_count",    want.used,    got.used);
        check_field("full_flag",     want.full,    got.full);
        check_field("last_flag",     want.last,    got.last);
      end
    end
  end

  initial begin
    directed_rows.push_back(dr(CMD_READ, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0));
    directed_rows.push_back(dr(CMD_DEL,  16'h1234, 0, 0, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0));
    directed_rows.push_back(dr(CMD_LIST, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0));
    directed_rows.push_back(dr(CMD_ADD,  16'h0000, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 1));
    directed_rows.push_back(dr(CMD_ADD,  16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                               7'h7F, 7'h7F, 7'h7F, 1, ST_OK, 2));
    directed_rows.push_back(dr(CMD_READ, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 2));
    directed_rows.push_back(dr(CMD_READ, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 2));
    directed_rows.push_back(dr(CMD_READ, 16'h5555, 0, 0, 0, 0, 0, 0, 0, 1, ST_NOTFOUND, 2));
    directed_rows.push_back(dr(CMD_DEL,  16'h5555, 0, 0, 0, 0, 0, 0, 0, 1, ST_NOTFOUND, 2));
    directed_rows.push_back(dr(CMD_ADD,  16'h00AA, 8'h5A, 8'h01, 8'h80, 8'h7F,
                               7'd100, 7'd101, 7'd99, 1, ST_OK, 3));
    directed_rows.push_back(dr(CMD_ADD,  16'h00AA, 8'hA5, 8'hFE, 8'h7F, 8'h80,
                               7'd0, 7'd127, 7'd64, 1, ST_OK, 4));
    directed_rows.push_back(dr(CMD_READ, 16'h00AA, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 4));
    directed_rows.push_back(dr(CMD_LIST, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 4));
    directed_rows.push_back(dr(CMD_ADD,  16'h0001, 8'h11, 8'h21, 8'h31, 8'h41,
                               7'd10, 7'd20, 7'd30, 1, ST_OK, 5));
    directed_rows.push_back(dr(CMD_ADD,  16'h0002, 8'h12, 8'h22, 8'h32, 8'h42,
                               7'd11, 7'd21, 7'd31, 1, ST_OK, 6));
    directed_rows.push_back(dr(CMD_ADD,  16'h0003, 8'h13, 8'h23, 8'h33, 8'h43,
                               7'd12, 7'd22, 7'd32, 1, ST_OK, 7));
    directed_rows.push_back(dr(CMD_ADD,  16'h0004, 8'h14, 8'h24, 8'h34, 8'h44,
                               7'd13, 7'd23, 7'd33, 1, ST_OK, 8));
    directed_rows.push_back(dr(CMD_ADD,  16'h0005, 8'h15, 8'h25, 8'h35, 8'h45,
                               7'd14, 7'd24, 7'd34, 1, ST_OK, 9));
    directed_rows.push_back(dr(CMD_ADD,  16'h0006, 8'h16, 8'h26, 8'h36, 8'h46,
                               7'd15, 7'd25, 7'd35, 1, ST_OK, 10));
    directed_rows.push_back(dr(CMD_ADD,  16'h0007, 8'h17, 8'h27, 8'h37, 8'h47,
                               7'd16, 7'd26, 7'd36, 1, ST_FULL, 10));
    directed_rows.push_back(dr(CMD_DEL,  16'h0000, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 9));
    directed_rows.push_back(dr(CMD_DEL,  16'h0006, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 8));
    directed_rows.push_back(dr(CMD_DEL,  16'h00AA, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 7));
    directed_rows.push_back(dr(CMD_LIST, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 7));
    directed_rows.push_back(dr(CMD_READ, 16'h00AA, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 7));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k])
      send_cmd(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    in_tvalid <= 1'b0;
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct   = idle_plan[p];
      recv_stall_pct <= stall_plan[p];
      if (p == 0) hold_start <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd(), 1'b0, '0);
      in_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("keyed_record_table: match");
    else
      $display("keyed_record_table: mismatch");
    $finish;
  end

endmodule

// ===== keyed_record_table.f =====
design/krt_pkg.sv
design/krt_ram.sv
design/keyed_record_table.sv
dv/tb_keyed_record_table.sv
